// ===== rtl/bpl_pkg.sv =====
// Package for the bounded pair list: item types, operation and status codes,
// and default sizes. No dependencies.
`timescale 1ns / 1ps

package bpl_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OP_W     = 2;
    localparam int FIELD_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 5;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] key_in;
        logic [FIELD_W-1:0] value_in;
        logic [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  key_out;
        logic [FIELD_W-1:0]  value_out;
        logic [HELD_W-1:0]   entries_held;
    } rsp_t;

endpackage

// ===== rtl/bpl_mem.sv =====
// Pair store: one write port, one read port, registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module bpl_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_array[rd_addr];
        end
    end

endmodule

// ===== rtl/bpl_ctrl.sv =====
// Sequencer for the pair list: holds the count, runs the duplicate scan and
// the remove shift against bpl_mem. Uses bpl_pkg.
`timescale 1ns / 1ps

module bpl_ctrl #(
    parameter int CAPACITY    = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bpl_pkg::req_t req,
    input  logic          allow_duplicates,
    output logic          res_valid,
    input  logic          res_ready,
    output bpl_pkg::rsp_t res,
    output logic          mem_wr_en,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_wr_addr,
    output logic [((KEY_WIDTH < 32) ? KEY_WIDTH : 32)
                  + ((VALUE_WIDTH < 32) ? VALUE_WIDTH : 32)-1:0] mem_wr_data,
    output logic          mem_rd_en,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_rd_addr,
    input  logic [((KEY_WIDTH < 32) ? KEY_WIDTH : 32)
                  + ((VALUE_WIDTH < 32) ? VALUE_WIDTH : 32)-1:0] mem_rd_data
);

    import bpl_pkg::*;

    // keys and values wider than the 32-bit fields only ever hold zeros up top
    localparam int KB    = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;
    localparam int VB    = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMP_W = POS_W + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [KB-1:0]    key_reg, key_next;
    logic [VB-1:0]    val_reg, val_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    rsp_t             res_reg, res_next;

    logic [KB-1:0]    rd_key;
    logic [VB-1:0]    rd_val;
    logic             full;
    logic [CMP_W-1:0] count_cmp;

    assign rd_key    = mem_rd_data[KB+VB-1:VB];
    assign rd_val    = mem_rd_data[VB-1:0];
    assign full      = (count_reg == CW'(CAPACITY));
    assign count_cmp = CMP_W'(count_reg);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        res_next    = res_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = count_reg[AW-1:0];
        mem_wr_data = {key_reg, val_reg};
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req.op;
                    key_next = req.key_in[KB-1:0];
                    val_next = req.value_in[VB-1:0];
                    pos_next = req.position;
                    res_next = '0;
                    res_next.entries_held = HELD_W'(count_reg);
                    state_next = S_DONE;
                    unique case (req.op) inside
                        OP_ADD:
                        begin
                            if (!allow_duplicates && (count_reg != '0))
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = '0;
                                idx_next    = CW'(1);
                                state_next  = S_SEARCH;
                            end
                            else if (full)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                mem_wr_en   = 1'b1;
                                mem_wr_data = {req.key_in[KB-1:0], req.value_in[VB-1:0]};
                                count_next  = count_reg + CW'(1);
                                res_next.entries_held = HELD_W'(count_next);
                            end
                        end
                        OP_REMOVE, OP_READ:
                        begin
                            if (CMP_W'(req.position) >= count_cmp)
                            begin
                                res_next.status = ST_RANGE;
                            end
                            else
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = AW'(req.position);
                                state_next  = S_FETCH;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_OK;
                        end
                    endcase
                end
            end

            // rd_data holds entry idx_reg-1; next read is issued in the same cycle
            S_SEARCH:
            begin
                if (rd_key == key_reg)
                begin
                    res_next.status = ST_DUP;
                    state_next      = S_DONE;
                end
                else if (idx_reg < count_reg)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_reg[AW-1:0];
                    idx_next    = idx_reg + CW'(1);
                end
                else if (full)
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    mem_wr_en  = 1'b1;
                    count_next = count_reg + CW'(1);
                    res_next.entries_held = HELD_W'(count_next);
                    state_next = S_DONE;
                end
            end

            S_FETCH:
            begin
                res_next.key_out   = FIELD_W'(rd_key);
                res_next.value_out = FIELD_W'(rd_val);
                if (op_reg == OP_READ)
                begin
                    state_next = S_DONE;
                end
                else if ((CMP_W'(pos_reg) + CMP_W'(1)) < count_cmp)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(pos_reg + POS_W'(1));
                    idx_next    = CW'(pos_reg);
                    state_next  = S_SHIFT;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    res_next.entries_held = HELD_W'(count_next);
                    state_next = S_DONE;
                end
            end

            // write entry idx_reg from idx_reg+1 while reading idx_reg+2
            S_SHIFT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_reg[AW-1:0];
                mem_wr_data = mem_rd_data;
                if ((CMP_W'(idx_reg) + CMP_W'(2)) < count_cmp)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = AW'(idx_reg + CW'(2));
                    idx_next    = idx_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    res_next.entries_held = HELD_W'(count_next);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
    end

endmodule

// ===== rtl/bounded_pair_list_top.sv =====
// Bounded pair list top level: config register, output register, and the
// sequencer plus pair store. Uses bpl_pkg, bpl_ctrl, bpl_mem.
//
// Usage:
//   req channel (req_valid/req_ready/req) takes one operation item: add a
//   pair, remove at index, or read at index. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns exactly one item per request, in order.
//   cfg_we/cfg_wdata write allow_duplicates (reset value 1); write it only
//   while the block is idle.
// Sequencing (output register free):
//   a plain add, a no-op or an out-of-range index goes from the accept state
//   straight to the done state; an in-range read passes through the fetch
//   state first. With duplicates disallowed an add scans the store, one read
//   per stored entry, and a match ends the scan early. A remove at index p
//   does one store read and write per moved entry. One item is in work at a
//   time; the next item is taken in the cycle after the previous result
//   leaves the sequencer.
// Reset clears the count (empty list) and all handshake state; the store
// needs no clearing. When the receiver stalls, the result waits in the
// output register and the sequencer can still finish one more item.
`timescale 1ns / 1ps

module bounded_pair_list_top #(
    parameter int CAPACITY    = bpl_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH   = bpl_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = bpl_pkg::VALUE_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bpl_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bpl_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic          cfg_wdata
);

    import bpl_pkg::*;

    localparam int KB = (KEY_WIDTH < FIELD_W) ? KEY_WIDTH : FIELD_W;
    localparam int VB = (VALUE_WIDTH < FIELD_W) ? VALUE_WIDTH : FIELD_W;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic          allow_dup_reg;
    logic          rsp_valid_reg;
    rsp_t          rsp_reg;

    logic          res_valid;
    logic          res_ready;
    rsp_t          res;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [KB+VB-1:0] mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [KB+VB-1:0] mem_rd_data;

    assign res_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_dup_reg <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                allow_dup_reg <= cfg_wdata;
            end
            if (res_ready)
            begin
                rsp_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    bpl_ctrl #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req              (req),
        .allow_duplicates (allow_dup_reg),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res),
        .mem_wr_en        (mem_wr_en),
        .mem_wr_addr      (mem_wr_addr),
        .mem_wr_data      (mem_wr_data),
        .mem_rd_en        (mem_rd_en),
        .mem_rd_addr      (mem_rd_addr),
        .mem_rd_data      (mem_rd_data)
    );

    bpl_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (KB + VB),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== tb/bpl_checker.sv =====
// Checker for the bounded pair list: watches the req, rsp and config ports,
// predicts every answer and compares it field by field. Uses bpl_pkg.
`timescale 1ns / 1ps

module bpl_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  bpl_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  bpl_pkg::rsp_t rsp,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    output int            mismatches,
    output int            outstanding
);
    import bpl_pkg::*;

    localparam int CAP = CAPACITY_DEF;

    logic [FIELD_W-1:0] key_tbl [CAP];
    logic [FIELD_W-1:0] val_tbl [CAP];
    int                 held = 0;
    logic               dup_ok = 1'b1;
    rsp_t               answers_due [$];
    int                 fails = 0;
    int                 reqs_taken = 0;
    int                 rsps_taken = 0;

    assign mismatches  = fails;
    assign outstanding = reqs_taken - rsps_taken;

    // Applies one operation to the shadow list and returns its answer.
    function automatic rsp_t apply_list_op(input req_t r);
        rsp_t a;
        logic hit;
        int   i;
        a = '0;
        a.status = ST_OK;
        hit = 1'b0;
        case (r.op)
            OP_ADD:
            begin
                for (i = 0; i < held; i++)
                    if (key_tbl[i] == r.key_in)
                        hit = 1'b1;
                // duplicate check has priority over fullness
                if (!dup_ok && hit)
                    a.status = ST_DUP;
                else if (held >= CAP)
                    a.status = ST_FULL;
                else
                begin
                    key_tbl[held] = r.key_in;
                    val_tbl[held] = r.value_in;
                    held++;
                end
            end
            OP_REMOVE, OP_READ:
            begin
                if (r.position >= held)
                    a.status = ST_RANGE;
                else
                begin
                    a.key_out   = key_tbl[r.position];
                    a.value_out = val_tbl[r.position];
                    if (r.op == OP_REMOVE)
                    begin
                        for (i = r.position; i < held - 1; i++)
                        begin
                            key_tbl[i] = key_tbl[i + 1];
                            val_tbl[i] = val_tbl[i + 1];
                        end
                        held--;
                    end
                end
            end
            default:
                ;   // op 3 leaves the list alone
        endcase
        a.entries_held = held[HELD_W-1:0];
        return a;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_we)
                dup_ok = cfg_wdata;
            if (rsp_valid && rsp_ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $display("%0t: unexpected item: status=%0d key=%h value=%h held=%0d",
                             $time, rsp.status, rsp.key_out, rsp.value_out,
                             rsp.entries_held);
                    fails++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (want.status !== rsp.status || want.key_out !== rsp.key_out ||
                        want.value_out !== rsp.value_out ||
                        want.entries_held !== rsp.entries_held)
                    begin
                        $display("%0t: mismatch: expected status=%0d key=%h value=%h held=%0d",
                                 $time, want.status, want.key_out, want.value_out,
                                 want.entries_held);
                        $display("%0t:           actual status=%0d key=%h value=%h held=%0d",
                                 $time, rsp.status, rsp.key_out, rsp.value_out,
                                 rsp.entries_held);
                        fails++;
                    end
                end
                rsps_taken <= rsps_taken + 1;
            end
            if (req_valid && req_ready)
            begin
                answers_due.insert(answers_due.size(), apply_list_op(req));
                reqs_taken <= reqs_taken + 1;
            end
        end
    end

endmodule

// ===== tb/tb_bounded_pair_list_top.sv =====
// Testbench top for bounded_pair_list_top: clock, reset, directed and random
// items, receiver stalls and verdict. Uses bpl_pkg and bpl_checker.
`timescale 1ns / 1ps

module tb_bounded_pair_list_top;
    import bpl_pkg::*;

    localparam logic [OP_W-1:0] OP_NOP = 2'd3;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_ready;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_ready;
    rsp_t  rsp;
    logic  cfg_we;
    logic  cfg_wdata;
    int    mismatches;
    int    outstanding;

    int                 burst_left = 0;
    logic [FIELD_W-1:0] key_pool [8];

    bounded_pair_list_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    bpl_checker i_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one item; bursts of random length, random gaps between them.
    task automatic push_item(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] k,
                             input logic [FIELD_W-1:0] v, input logic [POS_W-1:0] p);
        req_t r;
        r.op       = op;
        r.key_in   = k;
        r.value_in = v;
        r.position = p;
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        burst_left--;
        if (burst_left == 0)
            req_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        if (burst_left != 0)
        begin
            req_valid  <= 1'b0;
            burst_left = 0;
        end
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_dup_policy(input logic allow);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= allow;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver: ready patterns of random length, plus two long hold-offs.
    initial
    begin
        int cyc = 0;
        int hold_left = 0;
        int mode = 0;
        int mode_left = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
                cyc++;
            if (cyc == 3000 || cyc == 11000)
                hold_left = 300;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int                 i;
        int                 ph;
        int                 roll;
        int                 add_w;
        logic [OP_W-1:0]    op;
        logic [FIELD_W-1:0] k;
        logic [POS_W-1:0]   p;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        for (i = 0; i < 8; i++)
            key_pool[i] = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: index ops out of range; no-op answers zero
        push_item(OP_READ, $urandom, $urandom, 8'd0);
        push_item(OP_REMOVE, '1, '1, 8'hFF);
        push_item(OP_NOP, $urandom, $urandom, POS_W'($urandom));
        push_item(OP_ADD, '0, '0, '0);
        push_item(OP_ADD, '1, '1, 8'hFF);
        push_item(OP_ADD, '0, 32'h1234_5678, '0);   // equal key, allowed after reset
        push_item(OP_READ, '0, '0, 8'd1);
        push_item(OP_READ, '0, '0, 8'd3);
        push_item(OP_REMOVE, '0, '0, 8'd0);
        for (i = 0; i < 14; i++)
            push_item(OP_ADD, 32'h1000_0000 + i, $urandom, '0);
        push_item(OP_ADD, $urandom, $urandom, '0);  // full
        set_dup_policy(1'b0);
        push_item(OP_ADD, 32'h1000_0003, $urandom, '0);  // dup beats full
        push_item(OP_REMOVE, '0, '0, 8'd15);
        push_item(OP_REMOVE, '0, '0, 8'd0);
        push_item(OP_ADD, '0, $urandom, '0);

        // random phases, policy alternating, fill-heavy and drain-heavy mixes
        for (ph = 0; ph < 8; ph++)
        begin
            set_dup_policy(ph[0]);
            add_w = ((ph / 2) % 2 == 0) ? 65 : 35;
            for (i = 0; i < 100; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < add_w)
                    op = OP_ADD;
                else if (roll < add_w + (95 - add_w) / 2)
                    op = OP_REMOVE;
                else if (roll < 95)
                    op = OP_READ;
                else
                    op = OP_NOP;
                // reuse recent keys so duplicates show up
                if ($urandom_range(0, 1))
                    k = key_pool[$urandom_range(0, 7)];
                else
                begin
                    k = $urandom;
                    if ($urandom_range(0, 3) == 0)
                        key_pool[$urandom_range(0, 7)] = k;
                end
                if ($urandom_range(0, 4) == 0)
                    p = POS_W'($urandom_range(0, 255));
                else
                    p = POS_W'($urandom_range(0, 16));
                push_item(op, k, $urandom, p);
            end
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
